// File: rtl/loop_playback_fade_out_assert.svh
// Assertion macros shared by the loop playback fade-out RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef LOOP_PLAYBACK_FADE_OUT_ASSERT_SVH
`define LOOP_PLAYBACK_FADE_OUT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define LPFO_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define LPFO_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LPFO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lpfo_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and controller/datapath interface types for the
// loop playback fade-out block. No dependencies.
package lpfo_pkg;

  localparam int POS_W       = 31;
  localparam int SMP_W       = 16;
  localparam int FRAC_W      = 16;
  localparam int GAIN_W      = FRAC_W + 1;
  localparam int PROD_W      = SMP_W + GAIN_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_STEPS  = GAIN_W;
  localparam int MOD_STEPS   = POS_W;
  localparam int CNT_W       = $clog2(MOD_STEPS + 1);
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 64;

  localparam logic [GAIN_W-1:0] Q16_ONE = GAIN_W'(1) << FRAC_W;
  localparam logic [POS_W-1:0]  POS_MAX = '1;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FADE_START   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_BODY    = CFG_IDX_W'(4);

  // Input word kinds
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_SEEK  = 1'b1;

  // Controller to datapath: at most one operation per cycle
  typedef struct packed {
    logic capture;
    logic prep;
    logic classify;
    logic div_step;
    logic gain;
    logic scale;
    logic finish;
  } lpfo_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_go;
    logic div_last;
    logic is_seek;
  } lpfo_sts_t;

endpackage

// File: rtl/loop_playback_fade_out.sv
`timescale 1ns / 1ps
// Top level of the loop playback fade-out block: stream ports, config
// port, and the controller/datapath pair. Uses lpfo_pkg, lpfo_ctrl, lpfo_dp.
//
//   channel | direction | content
//   --------+-----------+----------------------------------------------------
//   in_     | slave     | one stereo frame or one seek command per word
//   out_    | master    | one result word per input word, in order
//   cfg_    | write     | five 31-bit registers; the user writes them only while the block is idle (not enforced)
//
// Per word, accept to next accept: a non-folding seek, an ended frame or a frame
//   outside the fade runs prep, classify, scale and output load; a frame inside the
//   fade adds 17 divider steps plus gain squaring, a folding seek 31 divider steps.
// Reset (rst_n low, synchronous) clears the registers, play position and out valid.
// A stalled output word holds; the next input word is still taken and worked on,
//   and waits only to load the output.
module loop_playback_fade_out import lpfo_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // left_in[15:0], right_in[31:16],
                                             // seek_target[62:32], zero [63]
  input  logic                   in_tuser,   // cmd: 0 frame, 1 seek
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // left_out[15:0], right_out[31:16],
                                             // engine_pos[62:32], zero [63]
  output logic                   out_tuser,  // ended
  // Configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [POS_W-1:0]       cfg_wdata
);

  lpfo_cmd_t        dp_cmd;
  lpfo_sts_t        dp_sts;
  logic [SMP_W-1:0] left_out, right_out;
  logic [POS_W-1:0] engine_pos;
  logic             ended;

  // Sequencing and handshakes
  lpfo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  // Arithmetic, position and register state; unpack the input word here
  lpfo_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd_in      (in_tuser),
    .left_in     (in_tdata[SMP_W-1:0]),
    .right_in    (in_tdata[2*SMP_W-1:SMP_W]),
    .seek_target (in_tdata[2*SMP_W+POS_W-1:2*SMP_W]),
    .cmd         (dp_cmd),
    .sts         (dp_sts),
    .left_out    (left_out),
    .right_out   (right_out),
    .engine_pos  (engine_pos),
    .ended       (ended)
  );

  // Pack the result word, pad to whole bytes
  assign out_tdata = {{(OUT_TDATA_W-2*SMP_W-POS_W){1'b0}}, engine_pos, right_out, left_out};
  assign out_tuser = ended;

endmodule

// File: rtl/lpfo_dp.sv
`timescale 1ns / 1ps
// Datapath: config registers, play position, shared restoring divider,
// gain squarer, sample scalers and output payload. Uses lpfo_pkg.
`include "loop_playback_fade_out_assert.svh"
module lpfo_dp import lpfo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [POS_W-1:0]         cfg_wdata,
  input  logic                     cmd_in,
  input  logic signed [SMP_W-1:0]  left_in,
  input  logic signed [SMP_W-1:0]  right_in,
  input  logic [POS_W-1:0]         seek_target,
  input  lpfo_cmd_t                cmd,
  output lpfo_sts_t                sts,
  output logic [SMP_W-1:0]         left_out,
  output logic [SMP_W-1:0]         right_out,
  output logic [POS_W-1:0]         engine_pos,
  output logic                     ended
);

  logic [POS_W-1:0] fade_start_r, fade_length_r, total_length_r, loop_start_r, loop_body_r;
  logic [POS_W-1:0] pos_r;

  logic                    cmd_r;
  logic signed [SMP_W-1:0] left_r, right_r;
  logic [POS_W-1:0]        tgt_in_r;

  logic [POS_W-1:0] tgt_r, d_r;
  logic             fade_on_r, end_r, loop_hit_r;

  logic [POS_W-1:0]  rem_r, dsh_r;
  logic [GAIN_W-1:0] q_r, gain_r;
  logic [CNT_W-1:0]  cnt_r;

  logic signed [PROD_W-1:0] prod_l_r, prod_r_r;

  logic [SMP_W-1:0] left_out_r, right_out_r;
  logic [POS_W-1:0] engine_pos_r;
  logic             ended_r;

  // prep
  logic             total_set;
  logic [POS_W-1:0] tgt_clamp;
  // classify
  logic [POS_W:0]   loop_end;
  logic             loop_hit, d_ge_l;
  logic [POS_W-1:0] fold_x, num_n;
  // divider step
  logic [POS_W-1:0] div_d;
  logic [POS_W:0]   div_r1, div_diff;
  logic             div_ge;
  // gain and finish
  logic [2*GAIN_W-1:0] gain_sq;
  logic [POS_W-1:0]    eng_fold;

  function automatic logic [SMP_W-1:0] q16_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-1:0] shifted;
    biased  = p + (p[PROD_W-1] ? PROD_W'((1 << FRAC_W) - 1) : PROD_W'(0));
    shifted = biased >>> FRAC_W;
    return shifted[SMP_W-1:0];
  endfunction

  assign total_set = (total_length_r != '0);
  assign tgt_clamp = (total_set && (tgt_in_r > total_length_r)) ? total_length_r : tgt_in_r;

  assign loop_end = {1'b0, loop_start_r} + {1'b0, loop_body_r};
  assign loop_hit = (loop_body_r != '0) && ({1'b0, tgt_r} >= loop_end);
  assign fold_x   = tgt_r - loop_end[POS_W-1:0];
  assign d_ge_l   = (d_r >= fade_length_r);
  assign num_n    = fade_length_r - d_r;

  assign div_d    = (cmd_r == CMD_SEEK) ? loop_body_r : fade_length_r;
  assign div_r1   = {rem_r, dsh_r[POS_W-1]};
  assign div_diff = div_r1 - {1'b0, div_d};
  assign div_ge   = (div_r1 >= {1'b0, div_d});

  assign gain_sq  = q_r * q_r;
  assign eng_fold = loop_start_r + rem_r;

  assign sts.is_seek  = (cmd_r == CMD_SEEK);
  assign sts.div_go   = (cmd_r == CMD_SEEK) ? loop_hit : (!end_r && fade_on_r && !d_ge_l);
  assign sts.div_last = (cnt_r == CNT_W'(1));

  // Configuration and play position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_start_r   <= '0;
      fade_length_r  <= '0;
      total_length_r <= '0;
      loop_start_r   <= '0;
      loop_body_r    <= '0;
      pos_r          <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FADE_START:   fade_start_r   <= cfg_wdata;
          REG_FADE_LENGTH:  fade_length_r  <= cfg_wdata;
          REG_TOTAL_LENGTH: total_length_r <= cfg_wdata;
          REG_LOOP_START:   loop_start_r   <= cfg_wdata;
          REG_LOOP_BODY:    loop_body_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        if (cmd_r == CMD_SEEK) begin
          pos_r <= tgt_r;
        end else if (!end_r && (pos_r != POS_MAX)) begin
          pos_r <= pos_r + POS_W'(1);
        end
      end
    end
  end

  // Divider counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.classify) begin
      cnt_r <= (cmd_r == CMD_SEEK) ? CNT_W'(MOD_STEPS) : CNT_W'(FRAC_STEPS);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Working payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= cmd_in;
      left_r   <= left_in;
      right_r  <= right_in;
      tgt_in_r <= seek_target;
    end
    if (cmd.prep) begin
      tgt_r     <= tgt_clamp;
      d_r       <= pos_r - fade_start_r;
      fade_on_r <= (fade_length_r != '0) && (pos_r >= fade_start_r);
      end_r     <= total_set && (pos_r >= total_length_r);
    end
    if (cmd.classify) begin
      loop_hit_r <= loop_hit;
      gain_r     <= fade_on_r ? '0 : Q16_ONE;
      q_r        <= '0;
      if (cmd_r == CMD_SEEK) begin
        rem_r <= '0;
        dsh_r <= fold_x;
      end else begin
        // n <= L, so n/2 already sits below the divisor
        rem_r <= {1'b0, num_n[POS_W-1:1]};
        dsh_r <= {num_n[0], {(POS_W-1){1'b0}}};
      end
    end
    if (cmd.div_step) begin
      rem_r <= div_ge ? div_diff[POS_W-1:0] : div_r1[POS_W-1:0];
      dsh_r <= {dsh_r[POS_W-2:0], 1'b0};
      q_r   <= {q_r[GAIN_W-2:0], div_ge};
    end
    if (cmd.gain) begin
      gain_r <= gain_sq[GAIN_W+FRAC_W-1:FRAC_W];
    end
    if (cmd.scale) begin
      prod_l_r <= left_r * $signed({1'b0, gain_r});
      prod_r_r <= right_r * $signed({1'b0, gain_r});
    end
    if (cmd.finish) begin
      if (cmd_r == CMD_SEEK) begin
        left_out_r   <= '0;
        right_out_r  <= '0;
        engine_pos_r <= loop_hit_r ? eng_fold : tgt_r;
        ended_r      <= 1'b0;
      end else if (end_r) begin
        left_out_r   <= '0;
        right_out_r  <= '0;
        engine_pos_r <= '0;
        ended_r      <= 1'b1;
      end else begin
        left_out_r   <= q16_trunc(prod_l_r);
        right_out_r  <= q16_trunc(prod_r_r);
        engine_pos_r <= '0;
        ended_r      <= 1'b0;
      end
    end
  end

  assign left_out   = left_out_r;
  assign right_out  = right_out_r;
  assign engine_pos = engine_pos_r;
  assign ended      = ended_r;

  `LPFO_ASSERT_IMPLIES(a_quot_range, cmd.gain, q_r <= Q16_ONE,
    "fade ratio quotient above unity")
  `LPFO_ASSERT_IMPLIES(a_fold_rem, cmd.finish && (cmd_r == CMD_SEEK) && loop_hit_r,
    rem_r < loop_body_r, "loop fold remainder not below loop body")
  `LPFO_ASSERT_IMPLIES(a_seek_clamp, cmd.finish && (cmd_r == CMD_SEEK) && total_set,
    tgt_r <= total_length_r, "seek target beyond total length")

endmodule

// File: rtl/lpfo_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one word through prep, classify, division, gain,
// scaling and output load; owns the handshakes. Uses lpfo_pkg.
`include "loop_playback_fade_out_assert.svh"
module lpfo_ctrl import lpfo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  lpfo_sts_t sts,
  output lpfo_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CLASS,
    S_DIV,
    S_GAIN,
    S_SCALE,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == S_IDLE) && in_tvalid;
    cmd.prep     = (state_r == S_PREP);
    cmd.classify = (state_r == S_CLASS);
    cmd.div_step = (state_r == S_DIV);
    cmd.gain     = (state_r == S_GAIN);
    cmd.scale    = (state_r == S_SCALE);
    cmd.finish   = (state_r == S_DONE) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_CLASS;
      S_CLASS: state_nxt = sts.div_go ? S_DIV : S_SCALE;
      S_DIV: begin
        if (sts.div_last) state_nxt = sts.is_seek ? S_SCALE : S_GAIN;
      end
      S_GAIN:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_DONE;
      S_DONE:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `LPFO_ASSERT_HOLDS(a_one_op, $onehot0(cmd), "more than one datapath operation at once")
  `LPFO_ASSERT_IMPLIES(a_no_overwrite, cmd.finish, slot_free,
    "output word overwritten before it was taken")
  `LPFO_ASSERT_NEXT(a_gain_after_div, cmd.div_step && sts.div_last && !sts.is_seek,
    cmd.gain, "fade division not followed by gain squaring")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for loop_playback_fade_out: a directed table, then randomized
// register phases, all scored against an in-bench playback and fade predictor.
// Depends on lpfo_pkg and the loop_playback_fade_out RTL.
module tb_top import lpfo_pkg::*; ();

  localparam int CYCLE_LIMIT   = 400_000;
  // Longer than the slowest word, a folding seek
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_PHASES = 16;
  // Final phases run with no idling on either side
  localparam int CALM_PHASES   = 3;
  localparam int MAX_REPORTS   = 10;
  // Indexes the block does not decode; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [SMP_W-1:0] left;
    logic [SMP_W-1:0] right;
    logic [POS_W-1:0] pos;
    logic             ended;
  } result_t;

  typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

  // One line of the directed table: an input word or a register write.
  // value carries the seek target of a word or the data of a write.
  typedef struct {
    row_kind_t            kind;
    logic                 cmd;
    logic [SMP_W-1:0]     left;
    logic [SMP_W-1:0]     right;
    logic [POS_W-1:0]     value;
    logic [CFG_IDX_W-1:0] index;
    logic                 typed;
    result_t              want;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = CMD_FRAME;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [POS_W-1:0]       cfg_wdata  = '0;

  // Predictor copy of the registers and the play position
  logic [POS_W-1:0] fade_start_q = '0;
  logic [POS_W-1:0] fade_len_q   = '0;
  logic [POS_W-1:0] total_len_q  = '0;
  logic [POS_W-1:0] loop_start_q = '0;
  logic [POS_W-1:0] loop_body_q  = '0;
  logic [POS_W-1:0] play_pos     = '0;

  result_t     pending_results[$];
  result_t     got_word;
  result_t     want_word;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned stall_left     = 0;
  bit          send_gaps      = 1'b0;
  bit          take_gaps      = 1'b0;

  loop_playback_fade_out dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Give up on a hung handshake
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // (1 - t)^2 in Q1.16; unity outside the fade, zero once the fade has run out
  function automatic u64_t fade_gain(logic [POS_W-1:0] pos);
    u64_t d;
    u64_t ratio;
    if (fade_len_q == '0 || pos < fade_start_q) return u64_t'(Q16_ONE);
    d = u64_t'(pos) - u64_t'(fade_start_q);
    if (d >= u64_t'(fade_len_q)) return 0;
    ratio = ((u64_t'(fade_len_q) - d) << FRAC_W) / u64_t'(fade_len_q);
    return (ratio * ratio) >> FRAC_W;
  endfunction

  // Signed divide truncates toward zero, as the block must
  function automatic logic [SMP_W-1:0] scale_sample(logic [SMP_W-1:0] s, u64_t gain);
    longint prod;
    prod = (longint'($signed(s)) * longint'(gain)) / longint'(Q16_ONE);
    return prod[SMP_W-1:0];
  endfunction

  // Fold a target at or past the loop end back into the loop body
  function automatic logic [POS_W-1:0] engine_frame(logic [POS_W-1:0] target);
    u64_t loop_end;
    loop_end = u64_t'(loop_start_q) + u64_t'(loop_body_q);
    if (loop_body_q == '0 || u64_t'(target) < loop_end) return target;
    return POS_W'(u64_t'(loop_start_q) +
                  (u64_t'(target) - loop_end) % u64_t'(loop_body_q));
  endfunction

  // Result of one accepted word; advances the predicted play position
  function automatic result_t play_word(logic cmd, logic [SMP_W-1:0] left,
                                        logic [SMP_W-1:0] right,
                                        logic [POS_W-1:0] target);
    result_t          outcome;
    logic [POS_W-1:0] tgt;
    u64_t             gain;
    outcome = '0;
    if (cmd == CMD_SEEK) begin
      tgt = target;
      if (total_len_q != '0 && tgt > total_len_q) tgt = total_len_q;
      play_pos    = tgt;
      outcome.pos = engine_frame(tgt);
    end else if (total_len_q != '0 && play_pos >= total_len_q) begin
      outcome.ended = 1'b1;
    end else begin
      gain          = fade_gain(play_pos);
      outcome.left  = scale_sample(left, gain);
      outcome.right = scale_sample(right, gain);
      if (play_pos != POS_MAX) play_pos = play_pos + 1'b1;
    end
    return outcome;
  endfunction

  // ---------------------------------------------------------------------------
  // Table rows and random values
  // ---------------------------------------------------------------------------

  function automatic result_t result_of(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r,
                                        logic [POS_W-1:0] p, logic e);
    return {l, r, p, e};
  endfunction

  function automatic stim_row_t word_row(logic cmd, logic [SMP_W-1:0] l,
                                         logic [SMP_W-1:0] r, logic [POS_W-1:0] tgt);
    stim_row_t row;
    row.kind  = ROW_WORD;
    row.cmd   = cmd;
    row.left  = l;
    row.right = r;
    row.value = tgt;
    row.index = '0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] index, logic [POS_W-1:0] value);
    stim_row_t row;
    row       = word_row(CMD_FRAME, '0, '0, value);
    row.kind  = ROW_REG;
    row.index = index;
    return row;
  endfunction

  // Attach a hand-computed result to a row
  function automatic stim_row_t typed_row(stim_row_t row, result_t want);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // Mostly small values so fades, ends and loop folds are reached quickly
  function automatic logic [POS_W-1:0] rand_reg(int unsigned small_hi);
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 4) return '0;
    if (pick < 14) return POS_W'($urandom_range(1, small_hi));
    if (pick < 17) return POS_MAX;
    return POS_W'($urandom());
  endfunction

  // A frame a little before or after an interesting point, clamped to 31 bits
  function automatic logic [POS_W-1:0] near_frame(longint base);
    longint probe;
    probe = base + longint'($urandom_range(0, 45)) - 5;
    if (probe < 0) return '0;
    if (probe > longint'(POS_MAX)) return POS_MAX;
    return POS_W'(probe);
  endfunction

  function automatic logic [POS_W-1:0] rand_target();
    case ($urandom_range(0, 6))
      0:       return near_frame(0);
      1:       return near_frame(longint'(fade_start_q));
      2:       return near_frame(longint'(fade_start_q) + longint'(fade_len_q));
      3:       return near_frame(longint'(total_len_q));
      4:       return near_frame(longint'(loop_start_q) + longint'(loop_body_q));
      5:       return POS_W'($urandom());
      default: return POS_W'($urandom_range(0, 900));
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until accepted, then queue its expected result.
  // Called at a rising edge; valid stays high into the next word unless a gap
  // is drawn.
  task automatic send_word(logic cmd, logic [SMP_W-1:0] l, logic [SMP_W-1:0] r,
                           logic [POS_W-1:0] tgt, logic typed, result_t want);
    result_t predicted;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    // left [15:0], right [31:16], seek target [62:32], zero [63]
    in_tdata  <= {1'b0, tgt, r, l};
    do @(posedge clk); while (!in_tready);
    predicted = play_word(cmd, l, r, tgt);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid, wait for every queued result, then let the block settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [POS_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (index)
      REG_FADE_START:   fade_start_q = value;
      REG_FADE_LENGTH:  fade_len_q   = value;
      REG_TOTAL_LENGTH: total_len_q  = value;
      REG_LOOP_START:   loop_start_q = value;
      REG_LOOP_BODY:    loop_body_q  = value;
      default: ;
    endcase
  endtask

  // Result side backpressure: out_tready drops for a random burst while take_gaps is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (take_gaps && $urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Score every accepted result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = {out_tdata[SMP_W-1:0], out_tdata[2*SMP_W-1:SMP_W],
                  out_tdata[2*SMP_W+POS_W-1:2*SMP_W], out_tuser};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result word: left %h right %h engine_pos %h ended %b",
                   got_word.left, got_word.right, got_word.pos, got_word.ended);
      end else begin
        want_word = pending_results.pop_front();
        if (got_word !== want_word) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"result mismatch: expected left %h right %h engine_pos %h ended %b,",
                      " got left %h right %h engine_pos %h ended %b"},
                     want_word.left, want_word.right, want_word.pos, want_word.ended,
                     got_word.left, got_word.right, got_word.pos, got_word.ended);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t   rows[$];
    int unsigned n_words;
    bit          calm;

    // Registers at reset: samples pass unchanged, nothing ends, no loop
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h7fff, 16'h8000, '0),
                             result_of(16'h7fff, 16'h8000, '0, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'hffff, 16'h0001, POS_MAX),
                             result_of(16'hffff, 16'h0001, '0, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, POS_MAX),
                             result_of('0, '0, POS_MAX, 1'b0)));
    // Position at its maximum: advance saturates
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h8000, 16'h7fff, '0),
                             result_of(16'h8000, 16'h7fff, '0, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h0000, 16'hffff, '0),
                             result_of(16'h0000, 16'hffff, '0, 1'b0)));

    // Fade 10..110, end at 200, loop section 50..80
    rows.push_back(reg_row(REG_FADE_START, 31'd10));
    rows.push_back(reg_row(REG_FADE_LENGTH, 31'd100));
    rows.push_back(reg_row(REG_TOTAL_LENGTH, 31'd200));
    rows.push_back(reg_row(REG_LOOP_START, 31'd50));
    rows.push_back(reg_row(REG_LOOP_BODY, 31'd30));
    rows.push_back(typed_row(word_row(CMD_SEEK, 16'hffff, 16'hffff, 31'd0),
                             result_of('0, '0, 31'd0, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h1234, 16'hedcb, '0),
                             result_of(16'h1234, 16'hedcb, '0, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, 31'd10),
                             result_of('0, '0, 31'd10, 1'b0)));
    // Fade start and the first step into the fade
    rows.push_back(word_row(CMD_FRAME, 16'h7fff, 16'h8000, '0));
    rows.push_back(word_row(CMD_FRAME, 16'h7fff, 16'h8000, '0));
    // Minus one scaled down truncates toward zero
    rows.push_back(word_row(CMD_FRAME, 16'hffff, 16'h0001, '0));
    // Seek past the loop end folds into the body
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, 31'd109),
                             result_of('0, '0, 31'd79, 1'b0)));
    rows.push_back(word_row(CMD_FRAME, 16'h8000, 16'h7fff, '0));
    // Fade has run out: silence
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h7fff, 16'h8000, '0),
                             result_of('0, '0, '0, 1'b0)));
    // Seek exactly at the loop end, then beyond the total length
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, 31'd80),
                             result_of('0, '0, 31'd50, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, 31'd500),
                             result_of('0, '0, 31'd50, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, 31'd199),
                             result_of('0, '0, 31'd79, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h7fff, 16'h7fff, '0),
                             result_of('0, '0, '0, 1'b0)));
    // Frame after the end is refused
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h7fff, 16'h7fff, '0),
                             result_of('0, '0, '0, 1'b1)));
    // Writes to undecoded indexes change nothing
    rows.push_back(reg_row(REG_SPARE_LO, '0));
    rows.push_back(reg_row(REG_SPARE_HI, POS_MAX));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, 31'd79),
                             result_of('0, '0, 31'd79, 1'b0)));
    rows.push_back(word_row(CMD_FRAME, 16'h4000, 16'hc000, '0));

    // Every register but the fade start at its maximum
    rows.push_back(reg_row(REG_FADE_START, '0));
    rows.push_back(reg_row(REG_FADE_LENGTH, POS_MAX));
    rows.push_back(reg_row(REG_TOTAL_LENGTH, POS_MAX));
    rows.push_back(reg_row(REG_LOOP_START, POS_MAX));
    rows.push_back(reg_row(REG_LOOP_BODY, POS_MAX));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, POS_MAX),
                             result_of('0, '0, POS_MAX, 1'b0)));
    rows.push_back(typed_row(word_row(CMD_FRAME, 16'h7fff, 16'h8000, '0),
                             result_of('0, '0, '0, 1'b1)));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, POS_MAX - 1'b1),
                             result_of('0, '0, POS_MAX - 1'b1, 1'b0)));
    rows.push_back(word_row(CMD_FRAME, 16'h8000, 16'h7fff, '0));
    // One-frame loop body folds everything to the loop start
    rows.push_back(reg_row(REG_LOOP_START, '0));
    rows.push_back(reg_row(REG_LOOP_BODY, 31'd1));
    rows.push_back(typed_row(word_row(CMD_SEEK, '0, '0, 31'd12345),
                             result_of('0, '0, '0, 1'b0)));
    rows.push_back(word_row(CMD_FRAME, 16'h8000, 16'h7fff, '0));

    repeat (11) @(posedge clk);
    rst_n     <= 1'b1;
    send_gaps  = 1'b1;
    take_gaps  = 1'b1;

    // Walk the directed table; registers change only once the block is idle
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(rows[i].index, rows[i].value);
      end else begin
        send_word(rows[i].cmd, rows[i].left, rows[i].right, rows[i].value,
                  rows[i].typed, rows[i].want);
      end
    end

    // Random phases: fresh registers, then runs of frames broken up by seeks
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      write_reg(REG_FADE_START, rand_reg(300));
      write_reg(REG_FADE_LENGTH, rand_reg(400));
      write_reg(REG_TOTAL_LENGTH, rand_reg(900));
      write_reg(REG_LOOP_START, rand_reg(300));
      write_reg(REG_LOOP_BODY, rand_reg(200));
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), POS_W'($urandom()));
      calm      = (ph >= RANDOM_PHASES - CALM_PHASES);
      send_gaps = !calm && ($urandom_range(0, 3) != 0);
      take_gaps = !calm && ($urandom_range(0, 3) != 0);
      n_words   = $urandom_range(80, 110);
      for (int k = 0; k < n_words; k++) begin
        if ($urandom_range(0, 11) == 0)
          send_word(CMD_SEEK, rand_sample(), rand_sample(), rand_target(), 1'b0, '0);
        else
          send_word(CMD_FRAME, rand_sample(), rand_sample(), POS_W'($urandom()), 1'b0, '0);
      end
    end

    // Drain the last results and let the block go quiet
    wait_idle();
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lpfo_pkg.sv
rtl/lpfo_dp.sv
rtl/lpfo_ctrl.sv
rtl/loop_playback_fade_out.sv
test/tb_top.sv
